/* rtl/nibble_run_length_encoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nibble run-length encoder
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define NIBBLE_RUN_LENGTH_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NRLE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NRLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/nrle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_pkg
// Shared constants and types of the nibble run-length encoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

   localparam int NIBBLE_BITS         = 4;
   localparam int CODE_BITS           = 2 * NIBBLE_BITS;
   localparam logic [NIBBLE_BITS-1:0] RUN_MAX = 4'd15;

   localparam int ROW_WIDTH_BITS      = 16;
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 16'd1;

   localparam int COLUMN_BITS_DEFAULT = 16;

   localparam int FIFO_DEPTH          = 4;
   localparam int FIFO_PTR_BITS       = 2;
   localparam int FIFO_COUNT_BITS     = 3;

   typedef struct packed {
      logic [CODE_BITS-1:0] run_code;
      logic                 closes_row;
      logic                 last_of_pixel;
   } nrle_code_type;

   // Up to two codes pushed in one cycle, packed from the first slot on.
   typedef struct packed {
      logic [1:0]    count;
      nrle_code_type first;
      nrle_code_type second;
   } nrle_push_type;

endpackage

/* rtl/nrle_code_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_code_fifo
// Small code queue: up to two codes in per cycle, one out per unstalled cycle.
// ----------------------------------------------------------------------------
module nrle_code_fifo
   import nrle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  nrle_push_type push,
   output logic          almost_full,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output nrle_code_type head
);

`include "nibble_run_length_encoder_top_macros.svh"

   nrle_code_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_next;
   logic                       pop;

   assign rsp_valid   = (count_ff != '0);
   assign head        = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign almost_full = (count_ff > FIFO_COUNT_BITS'(FIFO_DEPTH - 2));
   assign wr_ptr_next = FIFO_PTR_BITS'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = FIFO_PTR_BITS'(wr_ptr_ff + push.count);
      rd_ptr_in = FIFO_PTR_BITS'(rd_ptr_ff + {{(FIFO_PTR_BITS-1){1'b0}}, pop});
      count_in  = FIFO_COUNT_BITS'(count_ff + FIFO_COUNT_BITS'(push.count)
                                   - FIFO_COUNT_BITS'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   `NRLE_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= FIFO_COUNT_BITS'(FIFO_DEPTH), "code queue overflow")
   `NRLE_ASSERT_IMP(a_push_room, push.count != 2'd0, !almost_full, "push into a nearly full queue")
   `NRLE_ASSERT_NEXT(a_pop_only, pop && push.count == 2'd0, count_ff == $past(count_ff) - 1'b1, "pop did not drop the count")

endmodule

/* rtl/nibble_run_length_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_run_length_encoder_top
// Row-bounded run-length encoder for 4-bit pixels, one code byte per run.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while req_stall is low and answers with
// zero, one or two run codes per pixel. The run state and column counter
// update in the cycle a pixel is accepted; the codes go into a four-entry
// queue that delivers one code per cycle while rsp_stall is low, so the input
// runs at one pixel per clock as long as codes are drained at least as fast
// as they are made. req_stall rises while the queue holds more than two
// codes. A row_width write takes effect on the next pixel and leaves the open
// run and the column alone; a width of zero behaves like a width of one.
module nibble_run_length_encoder_top
   import nrle_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [ROW_WIDTH_BITS-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [NIBBLE_BITS-1:0]    req_pixel_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CODE_BITS-1:0]      rsp_run_code,
   output logic                      rsp_closes_row,
   output logic                      rsp_last_of_pixel
);

`include "nibble_run_length_encoder_top_macros.svh"

   localparam int CMP_BITS = (COLUMN_BITS >= ROW_WIDTH_BITS) ? COLUMN_BITS + 1
                                                             : ROW_WIDTH_BITS + 1;

   logic [ROW_WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic [NIBBLE_BITS-1:0]    open_value_ff, open_value_in;
   logic [NIBBLE_BITS-1:0]    open_length_ff, open_length_in;
   logic [COLUMN_BITS-1:0]    column_ff, column_in;

   logic                      accept;
   logic                      almost_full;
   logic [CMP_BITS-1:0]       column_plus_one;
   logic [CMP_BITS-1:0]       row_width_ext;
   logic                      row_end;
   logic                      value_change;
   logic                      close_now;
   logic [NIBBLE_BITS-1:0]    run_value;
   logic [NIBBLE_BITS-1:0]    run_length;
   nrle_code_type             change_code;
   nrle_code_type             close_code;
   nrle_push_type             push;
   nrle_code_type             head;

   assign accept    = req_valid && !req_stall;
   assign req_stall = almost_full;

   always_comb begin
      column_plus_one = {{(CMP_BITS-COLUMN_BITS){1'b0}}, column_ff} + CMP_BITS'(1);
      row_width_ext   = {{(CMP_BITS-ROW_WIDTH_BITS){1'b0}}, row_width_ff};
      row_end         = (column_plus_one >= row_width_ext) || (&column_ff);

      value_change = (open_length_ff != '0) && (req_pixel_value != open_value_ff);

      // A fresh run starts on an empty run or a value change.
      if (value_change || open_length_ff == '0) begin
         run_value  = req_pixel_value;
         run_length = NIBBLE_BITS'(1);
      end else begin
         run_value  = open_value_ff;
         run_length = NIBBLE_BITS'(open_length_ff + 1'b1);
      end
      close_now = row_end || (run_length >= RUN_MAX);

      change_code.run_code      = {open_length_ff, open_value_ff};
      change_code.closes_row    = 1'b0;
      change_code.last_of_pixel = !close_now;

      close_code.run_code       = {run_length, run_value};
      close_code.closes_row     = row_end;
      close_code.last_of_pixel  = 1'b1;

      push.count  = 2'd0;
      push.first  = close_code;
      push.second = close_code;
      if (accept) begin
         if (value_change) begin
            push.first = change_code;
            push.count = close_now ? 2'd2 : 2'd1;
         end else begin
            push.count = close_now ? 2'd1 : 2'd0;
         end
      end

      row_width_in   = csr_write_enable ? csr_write_data : row_width_ff;
      open_value_in  = open_value_ff;
      open_length_in = open_length_ff;
      column_in      = column_ff;
      if (accept) begin
         open_value_in  = run_value;
         open_length_in = close_now ? '0 : run_length;
         column_in      = row_end ? '0 : COLUMN_BITS'(column_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RESET;
         open_value_ff  <= '0;
         open_length_ff <= '0;
         column_ff      <= '0;
      end else begin
         row_width_ff   <= row_width_in;
         open_value_ff  <= open_value_in;
         open_length_ff <= open_length_in;
         column_ff      <= column_in;
      end
   end

   nrle_code_fifo u_code_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .almost_full (almost_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .head        (head)
   );

   assign rsp_run_code      = head.run_code;
   assign rsp_closes_row    = head.closes_row;
   assign rsp_last_of_pixel = head.last_of_pixel;

   `NRLE_ASSERT_IMP(a_close_is_last, rsp_valid && rsp_closes_row, rsp_last_of_pixel, "row close not last code of pixel")
   `NRLE_ASSERT_IMP(a_length_nonzero, rsp_valid, rsp_run_code[CODE_BITS-1:NIBBLE_BITS] != '0, "run code with zero length")
   `NRLE_ASSERT_NEXT(a_row_restart, accept && row_end, column_ff == '0 && open_length_ff == '0, "row end left state open")

endmodule
